@@ rtl/core/wfsc_pkg.sv @@
// Package for the wall-follow steering controller: types, codes and constants.
`default_nettype none

package wfsc_pkg;

  localparam int unsigned DistW  = 13;
  localparam int unsigned DiffW  = DistW + 1;
  localparam int unsigned ServoW = 10;
  localparam int unsigned SlewW  = 12;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 13;

  // Command codes.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FORCE = 1'b1;

  // Drive mode codes.
  localparam logic MODE_FOLLOW = 1'b0;
  localparam logic MODE_CORNER = 1'b1;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_FAR_LIMIT     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NEAR_LIMIT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CORNER_LIMIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLEW_PERIOD   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CONFIRM_COUNT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ALIGN_BAND    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CENTER_POS    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_WIDE_POS      = 3'd7;

  // Fixed steering constants.
  localparam logic [ServoW-1:0]        TOWARD_POS    = 10'd200;
  localparam logic signed [DiffW-1:0]  AWAY_DIFF_MIN = 14'sd5;
  localparam logic signed [DiffW-1:0]  TOWARD_DIFF_MAX = 14'sd0;
  localparam logic [ServoW-1:0]        SERVO_RESET   = 10'd250;
  localparam logic [CountW-1:0]        COUNT_MAX     = 8'd255;

  typedef struct packed {
    logic              cmd;
    logic [DistW-1:0]  dist_a;
    logic [DistW-1:0]  dist_b;
    logic              mode_value;
  } in_item_t;

  typedef struct packed {
    logic [ServoW-1:0] servo_pos;
    logic              drive_mode;
  } out_item_t;

  typedef struct packed {
    logic [DistW-1:0]  far_limit;
    logic [DistW-1:0]  near_limit;
    logic [DistW-1:0]  corner_limit;
    logic [SlewW-1:0]  slew_period;
    logic [CountW-1:0] confirm_count;
    logic [DistW-1:0]  align_band;
    logic [ServoW-1:0] center_pos;
    logic [ServoW-1:0] wide_pos;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [ServoW-1:0] servo;
    logic [SlewW-1:0]  slew_count;
    logic [CountW-1:0] confirm_counter;
  } ctrl_state_t;

endpackage

`default_nettype wire

@@ rtl/core/wfsc_step.sv @@
// Next-state logic for one transfer of the wall-follow steering controller.
`default_nettype none

module wfsc_step (
  input  wfsc_pkg::in_item_t    item_i,
  input  wfsc_pkg::cfg_t        cfg_i,
  input  wfsc_pkg::ctrl_state_t state_i,
  output wfsc_pkg::ctrl_state_t state_o
);
  import wfsc_pkg::*;

  logic signed [DiffW-1:0] diff;
  logic signed [DiffW-1:0] band;
  logic [ServoW-1:0]       target;
  logic                    qualifies;
  logic                    do_switch;
  logic [CountW-1:0]       counter_next;

  assign diff = $signed({1'b0, item_i.dist_b}) - $signed({1'b0, item_i.dist_a});
  assign band = $signed({1'b0, cfg_i.align_band});

  always_comb begin
    target = cfg_i.center_pos;
    if (item_i.dist_a >= cfg_i.far_limit) begin
      if (diff >= AWAY_DIFF_MIN) target = cfg_i.wide_pos;
    end else if (item_i.dist_a <= cfg_i.near_limit) begin
      if (diff <= TOWARD_DIFF_MAX) target = TOWARD_POS;
    end
  end

  // Follow mode looks for a far B; corner mode waits for the walls to line up.
  assign qualifies = (state_i.mode == MODE_FOLLOW) ?
                     (item_i.dist_b > cfg_i.corner_limit) :
                     ((diff < band) && (diff > -band));

  always_comb begin
    do_switch    = 1'b0;
    counter_next = state_i.confirm_counter;
    if (!qualifies) begin
      counter_next = '0;
    end else if (state_i.confirm_counter > cfg_i.confirm_count) begin
      do_switch = 1'b1;
    end else if (state_i.confirm_counter < COUNT_MAX) begin
      counter_next = state_i.confirm_counter + 1'b1;
    end
  end

  always_comb begin
    state_o = state_i;
    if (item_i.cmd == CMD_FORCE) begin
      state_o.mode = item_i.mode_value;
    end else if (state_i.mode == MODE_FOLLOW) begin
      if (state_i.servo != target) begin
        if (state_i.slew_count < cfg_i.slew_period) begin
          state_o.slew_count = state_i.slew_count + 1'b1;
        end else begin
          state_o.slew_count = '0;
          if (state_i.servo > target) state_o.servo = state_i.servo - 1'b1;
          else                        state_o.servo = state_i.servo + 1'b1;
        end
      end
      state_o.confirm_counter = counter_next;
      if (do_switch) state_o.mode = MODE_CORNER;
    end else begin
      state_o.servo           = cfg_i.wide_pos;
      state_o.confirm_counter = counter_next;
      if (do_switch) state_o.mode = MODE_FOLLOW;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wall_follow_steering_controller_unit.sv @@
// Top level of the wall-follow steering controller: registers, flow control, checks.
`default_nettype none

// The controller takes one input transfer per clock cycle while the result side
// does not stall, and returns exactly one result transfer for each. Every
// transfer passes an input register and then the result register. An accepted
// input is held in the input register, and its result is then written into the
// result register and offered from there. The throughput is one transfer per
// cycle when nothing stalls, set by the state update between those two
// registers. Command 0 is a control tick that runs the follow or corner logic on
// distances A and B; command 1 only forces the drive mode and reports the current
// servo position. The servo position and mode in each result are the values after
// that transfer. The configuration port may be written only while no transfer is
// in flight; all eight registers come up at their documented reset values.
module wall_follow_steering_controller_unit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wfsc_pkg::in_item_t                    in_item_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output wfsc_pkg::out_item_t                   out_item_o,
  input  wire                                   cfg_we_i,
  input  wire [wfsc_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire [wfsc_pkg::CfgDataW-1:0]          cfg_wdata_i
);
  import wfsc_pkg::*;

  cfg_t        cfg_q;
  ctrl_state_t state_q, state_d;
  in_item_t    in_q;
  logic        in_valid_q;
  out_item_t   out_q;
  logic        out_valid_q;
  logic        advance;
  logic        fire;

  // The result register frees up when it is empty or its transfer completes.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.far_limit     <= 13'd400;
      cfg_q.near_limit    <= 13'd350;
      cfg_q.corner_limit  <= 13'd800;
      cfg_q.slew_period   <= 12'd600;
      cfg_q.confirm_count <= 8'd5;
      cfg_q.align_band    <= 13'd50;
      cfg_q.center_pos    <= 10'd250;
      cfg_q.wide_pos      <= 10'd300;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FAR_LIMIT:     cfg_q.far_limit     <= cfg_wdata_i;
        REG_NEAR_LIMIT:    cfg_q.near_limit    <= cfg_wdata_i;
        REG_CORNER_LIMIT:  cfg_q.corner_limit  <= cfg_wdata_i;
        REG_SLEW_PERIOD:   cfg_q.slew_period   <= cfg_wdata_i[SlewW-1:0];
        REG_CONFIRM_COUNT: cfg_q.confirm_count <= cfg_wdata_i[CountW-1:0];
        REG_ALIGN_BAND:    cfg_q.align_band    <= cfg_wdata_i;
        REG_CENTER_POS:    cfg_q.center_pos    <= cfg_wdata_i[ServoW-1:0];
        REG_WIDE_POS:      cfg_q.wide_pos      <= cfg_wdata_i[ServoW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: it refills whenever it is empty or its current item moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  wfsc_step u_step (
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  // Controller state changes only when an item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= MODE_FOLLOW;
      state_q.servo           <= SERVO_RESET;
      state_q.slew_count      <= '0;
      state_q.confirm_counter <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.servo_pos  <= state_d.servo;
      out_q.drive_mode <= state_d.mode;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A stalled input can only come from a held item in the input register.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with no item held");

  // A corner-mode tick always reports the wide position.
  a_corner_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.cmd == CMD_TICK && state_q.mode == MODE_CORNER)
    |=> (out_q.servo_pos == $past(cfg_q.wide_pos)))
    else $error("corner tick did not report the wide position");

  // A follow tick moves the servo by at most one step.
  a_follow_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.cmd == CMD_TICK && state_q.mode == MODE_FOLLOW)
    |=> ((state_q.servo == $past(state_q.servo)) ||
         (state_q.servo == $past(state_q.servo) + 10'd1) ||
         (state_q.servo == $past(state_q.servo) - 10'd1)))
    else $error("servo moved more than one step in follow mode");

  // A forced mode change leaves the servo and the counters untouched.
  a_force_keeps_servo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.cmd == CMD_FORCE)
    |=> ($stable(state_q.servo) && $stable(state_q.slew_count) &&
         $stable(state_q.confirm_counter)))
    else $error("forced mode changed servo or counters");

endmodule

`default_nettype wire
